>>> hw/rtl/rpd_pkg.sv
// Shared types and constants of the run-length plane decoder.
package rpd_pkg;

  // Width of the decoded-byte counter; the usable plane size is capped at its maximum.
  localparam int COUNT_WIDTH = 16;
  localparam int PLANE_W     = 16;
  localparam int EXT_W       = (COUNT_WIDTH > PLANE_W) ? COUNT_WIDTH : PLANE_W;
  localparam logic [EXT_W-1:0] COUNT_MAX = EXT_W'({COUNT_WIDTH{1'b1}});

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_FILL_A      = 2'd0;
  localparam logic [1:0] REG_FILL_B      = 2'd1;
  localparam logic [1:0] REG_PLANE_BYTES = 2'd2;

  localparam logic [PLANE_W-1:0] PLANE_BYTES_RST = PLANE_W'(16000);

  // Run type in the top two bits of a control byte.
  localparam logic [1:0] TYP_REPEAT  = 2'b00;
  localparam logic [1:0] TYP_FILL_A  = 2'b01;
  localparam logic [1:0] TYP_FILL_B  = 2'b10;
  localparam logic [1:0] TYP_LITERAL = 2'b11;

  // Plane status codes.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_EARLY     = 3'd1;
  localparam logic [2:0] ERR_MISSING   = 3'd2;
  localparam logic [2:0] ERR_OVERRUN   = 3'd3;
  localparam logic [2:0] ERR_OVERSHOOT = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic last_push;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/rpd_ctrl.sv
// Sequencing state machine of the run-length plane decoder.
module rpd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rpd_pkg::sts_t sts,
  output rpd_pkg::cmd_t cmd
);
  import rpd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    cmd.push    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.commit = 1'b1;
        state_nxt  = sts.has_result ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.push = sts.out_free;
        if (sts.out_free && sts.last_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and the registered input stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != ST_IDLE);
    end
  end

  assign in_stall = in_stall_r;

  // A captured beat is always decided in the following cycle.
  a_capture_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.commit)
    else $error("captured beat was not committed in the next cycle");

  // The input is only open while no earlier beat is being worked on.
  a_stall_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL || state_r == ST_EMIT) |-> in_stall)
    else $error("input open while a beat is in progress");

  // Results are pushed only into a free output register.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> sts.out_free)
    else $error("push into an occupied output register");

endmodule

>>> hw/rtl/rpd_datapath.sv
// Decode state, run planning and output register of the run-length plane decoder.
module rpd_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  rpd_pkg::cmd_t cmd,
  output rpd_pkg::sts_t sts,
  input  logic [7:0]    in_comp_byte,
  input  logic          in_end_of_payload,
  input  logic [7:0]    fill_a,
  input  logic [7:0]    fill_b,
  input  logic [15:0]   plane_bytes,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_last_of_run,
  output logic          out_plane_done,
  output logic [2:0]    out_error_code
);
  import rpd_pkg::*;

  typedef enum logic [1:0] {PH_CTRL, PH_REPEAT, PH_LITERAL, PH_DRAIN} phase_t;

  // Captured beat.
  logic [7:0] c_r;
  logic       end_r;

  // Decode state carried between beats.
  phase_t                 phase_r, ph_nxt;
  logic [6:0]             run_left_r, rl_nxt;
  logic [COUNT_WIDTH-1:0] produced_r, prod_nxt;
  logic                   failed_r, fail_nxt;

  // Emission plan of the current beat.
  logic [7:0] val_r;
  logic [6:0] left_r;
  logic       byte_ok_r;
  logic       done_r;
  logic [2:0] code_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_byte_valid_r;
  logic       out_last_r;
  logic       out_done_r;
  logic [2:0] out_code_r;

  // Decision signals.
  logic [EXT_W-1:0] limit;
  logic [EXT_W-1:0] prod_ext;
  logic [EXT_W-1:0] room;
  logic [1:0]       typ;
  logic [6:0]       n;
  logic             run_emit;
  logic [6:0]       run_len;
  logic             over;
  logic [6:0]       cnt;
  logic [6:0]       rl_dec;
  logic [7:0]       val;
  logic             done;
  logic [2:0]       code;
  logic [6:0]       left_nxt;

  // Space left in the plane, with the size capped at the counter maximum.
  always_comb begin
    limit    = (EXT_W'(plane_bytes) < COUNT_MAX) ? EXT_W'(plane_bytes) : COUNT_MAX;
    prod_ext = EXT_W'(produced_r);
    room     = (prod_ext < limit) ? (limit - prod_ext) : '0;
  end

  assign typ = c_r[7:6];
  assign n   = {1'b0, c_r[5:0]} + 7'd1;

  // Work out the results and the next decode state for the captured beat.
  always_comb begin
    ph_nxt   = phase_r;
    rl_nxt   = run_left_r;
    fail_nxt = failed_r;
    cnt      = 7'd0;
    val      = c_r;
    done     = 1'b0;
    code     = ERR_OK;
    run_emit = 1'b0;
    run_len  = n;
    over     = 1'b0;
    rl_dec   = (run_left_r != 7'd0) ? (run_left_r - 7'd1) : 7'd0;
    unique case (phase_r)
      PH_CTRL: begin
        if (room == '0) begin
          done   = 1'b1;
          code   = ERR_TRAILING;
          ph_nxt = PH_DRAIN;
        end else begin
          unique case (typ)
            TYP_FILL_A: begin
              run_emit = 1'b1;
              val      = fill_a;
            end
            TYP_FILL_B: begin
              run_emit = 1'b1;
              val      = fill_b;
            end
            TYP_REPEAT: begin
              if (end_r) begin
                done = 1'b1;
                code = ERR_MISSING;
              end else begin
                ph_nxt = PH_REPEAT;
                rl_nxt = n;
              end
            end
            TYP_LITERAL: begin
              if (end_r) begin
                done = 1'b1;
                code = ERR_OVERRUN;
              end else begin
                ph_nxt   = PH_LITERAL;
                rl_nxt   = n;
                fail_nxt = 1'b0;
              end
            end
            default: begin
              ph_nxt = phase_r;
            end
          endcase
        end
      end
      PH_REPEAT: begin
        run_emit = 1'b1;
        run_len  = run_left_r;
      end
      PH_LITERAL: begin
        if (room != '0) begin
          cnt = 7'd1;
        end else begin
          fail_nxt = 1'b1;
        end
        rl_nxt = rl_dec;
        if (rl_dec != 7'd0) begin
          if (end_r) begin
            done = 1'b1;
            code = ERR_OVERRUN;
          end
        end else begin
          ph_nxt = PH_CTRL;
          if (fail_nxt) begin
            done = 1'b1;
            code = ERR_OVERSHOOT;
          end else if (room <= EXT_W'(1)) begin
            done = 1'b1;
            code = end_r ? ERR_OK : ERR_TRAILING;
          end else if (end_r) begin
            done = 1'b1;
            code = ERR_EARLY;
          end
          if (done) begin
            ph_nxt = PH_DRAIN;
          end
        end
      end
      PH_DRAIN: begin
        ph_nxt = PH_DRAIN;
      end
      default: begin
        ph_nxt = PH_CTRL;
      end
    endcase

    // A run is clipped at the plane size and then judged.
    if (run_emit) begin
      over   = EXT_W'(run_len) > room;
      cnt    = over ? room[6:0] : run_len;
      ph_nxt = PH_CTRL;
      rl_nxt = 7'd0;
      if (over) begin
        done = 1'b1;
        code = ERR_OVERSHOOT;
      end else if (EXT_W'(run_len) == room) begin
        done = 1'b1;
        code = end_r ? ERR_OK : ERR_TRAILING;
      end else if (end_r) begin
        done = 1'b1;
        code = ERR_EARLY;
      end
      if (done) begin
        ph_nxt = PH_DRAIN;
      end
    end
  end

  assign prod_nxt = COUNT_WIDTH'(prod_ext + EXT_W'(cnt));
  // A plane that ends with no byte still gives one status beat.
  assign left_nxt = (cnt != 7'd0) ? cnt : {6'd0, done};

  assign sts.has_result = (left_nxt != 7'd0);
  assign sts.last_push  = (left_r == 7'd1);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Beat capture and emission plan.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_r   <= in_comp_byte;
      end_r <= in_end_of_payload;
    end
    if (cmd.commit) begin
      val_r     <= val;
      byte_ok_r <= (cnt != 7'd0);
      done_r    <= done;
      code_r    <= code;
    end
  end

  // Decode state and result counter; the final payload beat clears the state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CTRL;
      run_left_r <= 7'd0;
      produced_r <= '0;
      failed_r   <= 1'b0;
      left_r     <= 7'd0;
    end else begin
      if (cmd.commit) begin
        left_r <= left_nxt;
        if (end_r) begin
          phase_r    <= PH_CTRL;
          run_left_r <= 7'd0;
          produced_r <= '0;
          failed_r   <= 1'b0;
        end else begin
          phase_r    <= ph_nxt;
          run_left_r <= rl_nxt;
          produced_r <= prod_nxt;
          failed_r   <= fail_nxt;
        end
      end else if (cmd.push) begin
        left_r <= left_r - 7'd1;
      end
    end
  end

  // Output register: one result beat at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte_r       <= byte_ok_r ? val_r : 8'h00;
      out_byte_valid_r <= byte_ok_r;
      out_last_r       <= (left_r == 7'd1);
      out_done_r       <= (left_r == 7'd1) && done_r;
      out_code_r       <= ((left_r == 7'd1) && done_r) ? code_r : ERR_OK;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_valid  = out_byte_valid_r;
  assign out_last_of_run = out_last_r;
  assign out_plane_done  = out_done_r;
  assign out_error_code  = out_code_r;

  // A run never plans more results than the longest control run.
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 7'd64)
    else $error("result count beyond the longest run");

  // Plane status only travels on the last result of a beat.
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("plane status on a result that is not the last");

  // An error code is reported only together with plane completion.
  a_code_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_code_r != ERR_OK)) |-> out_done_r)
    else $error("error code without plane completion");

endmodule

>>> hw/rtl/rle_plane_decoder.sv
// Top level of the run-length plane decoder: register port and unit wiring.
//
//   channel  signals                                    handshake
//   in       in_comp_byte, in_end_of_payload           in_valid / in_stall
//   out      out_byte, out_byte_valid, out_last_of_run, out_valid / out_stall
//            out_plane_done, out_error_code
//   cfg      psel, penable, pwrite, paddr, pwdata,      pready, always high
//            prdata
//
// An input beat is captured, then decided, and then its result beats, up to 64, are emitted;
// the single output register, loaded with one result per cycle while the output is not stalled,
// sets the length of a run's emission.
// A stall on the output holds the emission in place and keeps the input stalled.
// Reset is synchronous and active low; it clears the decode state and the registers to
// fill bytes 0 and a plane size of 16000.
module rle_plane_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_comp_byte,
  input  logic        in_end_of_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_of_run,
  output logic        out_plane_done,
  output logic [2:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rpd_pkg::*;

  logic [7:0]         fill_a_r;
  logic [7:0]         fill_b_r;
  logic [PLANE_W-1:0] plane_bytes_r;
  logic               cfg_wr;
  logic [1:0]         reg_idx;
  cmd_t               cmd;
  sts_t               sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_a_r      <= 8'h00;
      fill_b_r      <= 8'h00;
      plane_bytes_r <= PLANE_BYTES_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FILL_A:      fill_a_r      <= pwdata[7:0];
        REG_FILL_B:      fill_b_r      <= pwdata[7:0];
        REG_PLANE_BYTES: plane_bytes_r <= pwdata[PLANE_W-1:0];
        default: begin
          fill_a_r <= fill_a_r;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_FILL_A:      prdata = {24'd0, fill_a_r};
      REG_FILL_B:      prdata = {24'd0, fill_b_r};
      REG_PLANE_BYTES: prdata = {{(32-PLANE_W){1'b0}}, plane_bytes_r};
      default:         prdata = 32'd0;
    endcase
  end

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_comp_byte      (in_comp_byte),
    .in_end_of_payload (in_end_of_payload),
    .fill_a            (fill_a_r),
    .fill_b            (fill_b_r),
    .plane_bytes       (plane_bytes_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_last_of_run   (out_last_of_run),
    .out_plane_done    (out_plane_done),
    .out_error_code    (out_error_code)
  );

endmodule
